// ----- rtl/rtc_pkg.sv -----
// Shared types and constants for the calendar keeper.
`timescale 1ns / 1ps
package rtc_pkg;

  // Access codes
  localparam logic [1:0] OP_READ     = 2'd0;
  localparam logic [1:0] OP_SET_DATE = 2'd1;
  localparam logic [1:0] OP_SET_TIME = 2'd2;

  // Configuration register indexes
  localparam logic REG_YEAR_MIN = 1'b0;
  localparam logic REG_YEAR_MAX = 1'b1;

  // Divider remainder width: holds any remainder of the largest divisor
  localparam int unsigned REM_W = 17;

  localparam logic [REM_W-1:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [REM_W-1:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [REM_W-1:0] SEC_PER_MIN  = 17'd60;
  localparam logic [REM_W-1:0] YEAR_CYCLE   = 17'd400;

  localparam logic [4:0] HOURS_PER_DAY = 5'd24;
  localparam logic [5:0] MIN_PER_HOUR  = 6'd60;
  localparam logic [5:0] MAX_DAY       = 6'd31;
  localparam logic [3:0] MAX_MONTH     = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_DAY,
    ST_DIV_HR,
    ST_DIV_MIN,
    ST_MOD_YR,
    ST_ADV,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/rtc_sdiv.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rtc_sdiv import rtc_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [W-1:0]     dividend,
  input  logic [REM_W-1:0] divisor,
  output logic             done,
  output logic [W-1:0]     quot,
  output logic [REM_W-1:0] rem
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [W-1:0]     q;
  logic [REM_W-1:0] r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [REM_W:0]   trial;
  logic             ge;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {r, q[W-1]};
    ge    = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient bits replace dividend bits as they shift out
  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
    end else if (busy) begin
      q <= {q[W-2:0], ge};
      r <= ge ? REM_W'(trial - {1'b0, divisor}) : trial[REM_W-1:0];
    end
  end

  assign quot = q;
  assign rem  = r;

endmodule

// ----- rtl/rtc_cal.sv -----
// Stored date with one-day advance under Gregorian rules.
`timescale 1ns / 1ps
module rtc_cal import rtc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [5:0]  ld_day,
  input  logic [3:0]  ld_month,
  input  logic [15:0] ld_year,
  input  logic [8:0]  ld_ymod,
  input  logic        step,
  output logic [5:0]  day,
  output logic [3:0]  month,
  output logic [15:0] year
);

  logic [8:0] ymod;   // year modulo 400
  logic       leap;
  logic [5:0] len;

  // Leap: divisible by 4, not a century unless divisible by 400
  always_comb begin
    leap = (year[1:0] == 2'd0) && !(ymod == 9'd100 || ymod == 9'd200 || ymod == 9'd300);
    case (month)
      4'd4, 4'd6, 4'd9, 4'd11: len = 6'd30;
      4'd2:                    len = leap ? 6'd29 : 6'd28;
      default:                 len = 6'd31;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      day   <= '0;
      month <= '0;
      year  <= '0;
      ymod  <= '0;
    end else if (load) begin
      day   <= ld_day;
      month <= ld_month;
      year  <= ld_year;
      ymod  <= ld_ymod;
    end else if (step && month != 4'd0 && month <= MAX_MONTH) begin
      // Advance one day, rolling month and year
      if (day < len) begin
        day <= day + 6'd1;
      end else if (month == MAX_MONTH) begin
        day   <= 6'd1;
        month <= 4'd1;
        year  <= year + 16'd1;
        if (year == 16'hFFFF || ymod == 9'(YEAR_CYCLE - 17'd1)) begin
          ymod <= '0;
        end else begin
          ymod <= ymod + 9'd1;
        end
      end else begin
        day   <= 6'd1;
        month <= month + 4'd1;
      end
    end
  end

endmodule

// ----- rtl/rtc_time_and_calendar_core.sv -----
// Top level: access sequencer, shared serial divider and calendar.
// Read: three divider passes (days, hours, minutes), then one day step per whole day.
// Set date: two divider passes (year modulo 400, days); set time and rejects skip the divider.
// One item at a time; the bit-serial divider and the day-step loop set the rate.
// A finished item waits in the output register while the next one is taken.
// Synchronous reset: date cleared to zero, year limits to 1993 and 2020.
`timescale 1ns / 1ps
module rtc_time_and_calendar_core import rtc_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] counter_value,
  input  logic [4:0]  set_hour,
  input  logic [5:0]  set_minute,
  input  logic [5:0]  set_second,
  input  logic [5:0]  set_day,
  input  logic [3:0]  set_month,
  input  logic [15:0] set_year,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [4:0]  day,
  output logic [3:0]  month,
  output logic [15:0] year,
  output logic [31:0] counter_write,
  output logic        counter_write_valid
);

  localparam int unsigned CW = COUNTER_WIDTH;
  localparam int unsigned DW = CW - 16;   // whole days in the counter

  state_t state, state_next;

  logic [15:0]    year_min, year_max;
  logic [1:0]     op;
  logic [CW-1:0]  sec;
  logic [DW-1:0]  days, days_left;
  logic [4:0]     r_hour;
  logic [5:0]     r_minute, r_second;
  logic           r_status;
  logic [CW-1:0]  r_cw;
  logic           r_cwv;
  logic [5:0]     sd;
  logic [3:0]     smo;
  logic [15:0]    sy;

  logic             div_start, div_done;
  logic [CW-1:0]    div_dividend, div_quot;
  logic [REM_W-1:0] div_divisor, div_rem;

  logic        cal_load, cal_step;
  logic [5:0]  cal_day;
  logic [3:0]  cal_month;
  logic [15:0] cal_year;

  logic        accept, out_free;
  logic        date_bad, time_bad;
  logic [REM_W-1:0] time_secs;

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  assign date_bad = (set_day > MAX_DAY) || (set_month > MAX_MONTH) ||
                    (set_year > year_max) || (set_year < year_min);
  assign time_bad = (set_hour >= HOURS_PER_DAY) || (set_minute >= MIN_PER_HOUR) ||
                    (set_second >= MIN_PER_HOUR);
  assign time_secs = REM_W'(set_hour) * SEC_PER_HOUR + REM_W'(set_minute) * SEC_PER_MIN +
                     REM_W'(set_second);

  rtc_sdiv #(.W(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  rtc_cal u_cal (
    .clk      (clk),
    .rst      (rst),
    .load     (cal_load),
    .ld_day   (sd),
    .ld_month (smo),
    .ld_year  (sy),
    .ld_ymod  (div_rem[8:0]),
    .step     (cal_step),
    .day      (cal_day),
    .month    (cal_month),
    .year     (cal_year)
  );

  // Hold the year limits
  always_ff @(posedge clk) begin
    if (rst) begin
      year_min <= 16'd1993;
      year_max <= 16'd2020;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_YEAR_MIN: year_min <= cfg_data;
        REG_YEAR_MAX: year_max <= cfg_data;
        default:      year_max <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Sequence the divider passes and the day steps
  always_comb begin
    state_next   = state;
    in_ready     = (state == ST_IDLE);
    div_start    = 1'b0;
    div_dividend = sec;
    cal_load     = 1'b0;
    cal_step     = (state == ST_ADV);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (opcode)
            OP_READ: begin
              div_start    = 1'b1;
              div_dividend = counter_value[CW-1:0];
              state_next   = ST_DIV_DAY;
            end
            OP_SET_DATE: begin
              if (!date_bad) begin
                div_start    = 1'b1;
                div_dividend = CW'(set_year);
                state_next   = ST_MOD_YR;
              end else begin
                state_next = ST_DONE;
              end
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_MOD_YR: begin
        if (div_done) begin
          cal_load     = 1'b1;
          div_start    = 1'b1;
          div_dividend = sec;
          state_next   = ST_DIV_DAY;
        end
      end
      ST_DIV_DAY: begin
        if (div_done) begin
          if (op == OP_READ) begin
            div_start    = 1'b1;
            div_dividend = CW'(div_rem);
            state_next   = ST_DIV_HR;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DIV_HR: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = CW'(div_rem);
          state_next   = ST_DIV_MIN;
        end
      end
      ST_DIV_MIN: begin
        if (div_done) state_next = (days != '0) ? ST_ADV : ST_DONE;
      end
      ST_ADV: begin
        if (days_left == DW'(1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_MOD_YR:  div_divisor = YEAR_CYCLE;
      ST_DIV_HR:  div_divisor = SEC_PER_HOUR;
      ST_DIV_MIN: div_divisor = SEC_PER_MIN;
      default:    div_divisor = SEC_PER_DAY;
    endcase
  end

  // Capture operands and partial results
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= opcode;
      sec      <= counter_value[CW-1:0];
      sd       <= set_day;
      smo      <= set_month;
      sy       <= set_year;
      r_hour   <= '0;
      r_minute <= '0;
      r_second <= '0;
      days     <= '0;
      r_cw     <= '0;
      r_cwv    <= 1'b0;
      r_status <= 1'b0;
      case (opcode)
        OP_READ: ;
        OP_SET_DATE: r_status <= date_bad;
        OP_SET_TIME: begin
          r_status <= time_bad;
          if (!time_bad) begin
            r_cw  <= CW'(time_secs);
            r_cwv <= 1'b1;
          end
        end
        default: r_status <= 1'b1;
      endcase
    end else if (div_done) begin
      case (state)
        ST_DIV_DAY: begin
          days <= div_quot[DW-1:0];
          if (div_quot[DW-1:0] != '0) begin
            r_cw  <= CW'(div_rem);
            r_cwv <= 1'b1;
          end
        end
        ST_DIV_HR: r_hour <= div_quot[4:0];
        ST_DIV_MIN: begin
          r_minute  <= div_quot[5:0];
          r_second  <= div_rem[5:0];
          days_left <= days;
        end
        default: ;
      endcase
    end else if (state == ST_ADV) begin
      days_left <= days_left - DW'(1);
    end
  end

  // Present the finished item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      status              <= r_status;
      hour                <= r_hour;
      minute              <= r_minute;
      second              <= r_second;
      day                 <= cal_day[4:0];
      month               <= cal_month;
      year                <= cal_year;
      counter_write       <= 32'(r_cw);
      counter_write_valid <= r_cwv;
    end
  end

  // No write-back value without the write-back flag
  a_cw_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (counter_write_valid || counter_write == 32'd0))
    else $error("counter_write nonzero without write back");

  // A rejected item never asks for a write back
  a_reject_no_wb: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> !counter_write_valid)
    else $error("rejected item requests write back");

  // Time fields are only filled by a read
  a_reject_no_time: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (hour == 5'd0 && minute == 6'd0 && second == 6'd0))
    else $error("rejected item carries a time");

  // Input is only taken with no item in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while busy");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the calendar keeper core.
`timescale 1ns / 1ps
module testbench;
  import rtc_pkg::*;

  typedef struct {
    logic [1:0]  opcode;
    logic [31:0] counter_value;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
    logic [5:0]  set_day;
    logic [3:0]  set_month;
    logic [15:0] set_year;
  } access_t;

  typedef struct {
    logic        status;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [31:0] counter_write;
    logic        counter_write_valid;
  } reply_t;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned DAY_SECS = 86400;

  // Calendar predictor and store of pending replies
  class calendar_scoreboard;
    logic [15:0] year_lo, year_hi;
    logic [5:0]  day_q;
    logic [3:0]  month_q;
    logic [15:0] year_q;
    reply_t      pending[$];
    int          errors;

    function new();
      year_lo = 16'd1993;
      year_hi = 16'd2020;
      day_q = '0;
      month_q = '0;
      year_q = '0;
      errors = 0;
    endfunction

    function void set_limit(logic idx, logic [15:0] val);
      if (idx == REG_YEAR_MIN) year_lo = val;
      else year_hi = val;
    endfunction

    function int unsigned days_in_month(logic [3:0] m, logic [15:0] y);
      bit leap;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      if (m == 2) return leap ? 29 : 28;
      return 31;
    endfunction

    // Advance the stored date by one day; bad months hold
    function void step_day();
      if (month_q == 0 || month_q > 12) return;
      if (day_q < days_in_month(month_q, year_q)) begin
        day_q = day_q + 6'd1;
      end else if (month_q == 12) begin
        day_q = 6'd1;
        month_q = 4'd1;
        year_q = year_q + 16'd1;
      end else begin
        day_q = 6'd1;
        month_q = month_q + 4'd1;
      end
    endfunction

    function void note_input(access_t a);
      reply_t r;
      int unsigned secs, hrs, days;
      r = '{default: '0};
      secs = a.counter_value;
      case (a.opcode)
        OP_READ: begin
          hrs = secs / 3600;
          r.minute = 6'((secs % 3600) / 60);
          r.second = 6'((secs % 3600) % 60);
          if (hrs >= 24) begin
            days = hrs / 24;
            r.hour = 5'(hrs % 24);
            r.counter_write = secs - days * DAY_SECS;
            r.counter_write_valid = 1'b1;
            for (int unsigned i = 0; i < days; i++) step_day();
          end else begin
            r.hour = 5'(hrs);
          end
        end
        OP_SET_DATE: begin
          if (a.set_day > 31 || a.set_month > 12 || a.set_year > year_hi ||
              a.set_year < year_lo) begin
            r.status = 1'b1;
          end else begin
            day_q = a.set_day;
            month_q = a.set_month;
            year_q = a.set_year;
            if (secs >= DAY_SECS) begin
              r.counter_write = secs % DAY_SECS;
              r.counter_write_valid = 1'b1;
            end
          end
        end
        OP_SET_TIME: begin
          if (a.set_hour >= 24 || a.set_minute >= 60 || a.set_second >= 60) begin
            r.status = 1'b1;
          end else begin
            r.counter_write = a.set_hour * 3600 + a.set_minute * 60 + a.set_second;
            r.counter_write_valid = 1'b1;
          end
        end
        default: r.status = 1'b1;
      endcase
      r.day = day_q[4:0];
      r.month = month_q;
      r.year = year_q;
      pending.push_back(r);
    endfunction

    function void check_result(reply_t got);
      reply_t exp;
      if (pending.size() == 0) begin
        $error("reply with nothing pending");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d actual %0d", exp.status, got.status); errors++;
      end
      if (got.hour !== exp.hour) begin
        $error("hour: expected %0d actual %0d", exp.hour, got.hour); errors++;
      end
      if (got.minute !== exp.minute) begin
        $error("minute: expected %0d actual %0d", exp.minute, got.minute); errors++;
      end
      if (got.second !== exp.second) begin
        $error("second: expected %0d actual %0d", exp.second, got.second); errors++;
      end
      if (got.day !== exp.day) begin
        $error("day: expected %0d actual %0d", exp.day, got.day); errors++;
      end
      if (got.month !== exp.month) begin
        $error("month: expected %0d actual %0d", exp.month, got.month); errors++;
      end
      if (got.year !== exp.year) begin
        $error("year: expected %0d actual %0d", exp.year, got.year); errors++;
      end
      if (got.counter_write !== exp.counter_write) begin
        $error("counter_write: expected %0d actual %0d",
               exp.counter_write, got.counter_write); errors++;
      end
      if (got.counter_write_valid !== exp.counter_write_valid) begin
        $error("counter_write_valid: expected %0d actual %0d",
               exp.counter_write_valid, got.counter_write_valid); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [31:0] counter_value = '0;
  logic [4:0]  set_hour = '0;
  logic [5:0]  set_minute = '0;
  logic [5:0]  set_second = '0;
  logic [5:0]  set_day = '0;
  logic [3:0]  set_month = '0;
  logic [15:0] set_year = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        status;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [15:0] year;
  logic [31:0] counter_write;
  logic        counter_write_valid;

  calendar_scoreboard sb = new();
  int burst_left = 0;

  rtc_time_and_calendar_core uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("rtc_time_and_calendar_core regression: fail");
    $finish;
  end

  // Receiver: shifting stall pattern, one long hold-off after 50 replies
  int replies_seen = 0;
  int hold_cnt = 0;
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_result('{status, hour, minute, second, day, month, year,
                          counter_write, counter_write_valid});
        replies_seen++;
        if (replies_seen == 50) hold_cnt = 3000;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 128);
      end else begin
        mode_left--;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic access_t make_access(logic [1:0] op, logic [31:0] cnt,
                                          logic [4:0] h, logic [5:0] m,
                                          logic [5:0] s, logic [5:0] d,
                                          logic [3:0] mo, logic [15:0] y);
    access_t a;
    a = '{op, cnt, h, m, s, d, mo, y};
    return a;
  endfunction

  // Offer one item, hold it until taken, then maybe open a gap
  task automatic send_access(access_t a);
    opcode <= a.opcode;
    counter_value <= a.counter_value;
    set_hour <= a.set_hour;
    set_minute <= a.set_minute;
    set_second <= a.set_second;
    set_day <= a.set_day;
    set_month <= a.set_month;
    set_year <= a.set_year;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(a);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic write_limit(logic idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_limit(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain all pending replies before touching the limits
  task automatic set_limits(logic [15:0] lo, logic [15:0] hi);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    write_limit(REG_YEAR_MIN, lo);
    write_limit(REG_YEAR_MAX, hi);
  endtask

  function automatic access_t random_access();
    access_t a;
    int unsigned pick;
    a = '{2'($urandom), $urandom, 5'($urandom), 6'($urandom), 6'($urandom),
          6'($urandom), 4'($urandom), 16'($urandom)};
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      a.opcode = OP_READ;
      case ($urandom_range(0, 99))
        0: ;
        1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20,
        21, 22, 23, 24, 25, 26, 27, 28, 29:
          a.counter_value = $urandom_range(0, DAY_SECS * 40);
        default: a.counter_value = $urandom_range(0, DAY_SECS * 4);
      endcase
    end else if (pick < 65) begin
      a.opcode = OP_SET_DATE;
      a.set_day = 6'($urandom_range(0, 31));
      a.set_month = 4'($urandom_range(0, 12));
      if (sb.year_lo <= sb.year_hi && $urandom_range(0, 4) != 0)
        a.set_year = 16'($urandom_range(sb.year_lo, sb.year_hi));
      if ($urandom_range(0, 1)) a.counter_value = $urandom_range(0, DAY_SECS * 2);
    end else if (pick < 90) begin
      a.opcode = OP_SET_TIME;
      a.set_hour = 5'($urandom_range(0, 23));
      a.set_minute = 6'($urandom_range(0, 59));
      a.set_second = 6'($urandom_range(0, 59));
    end else if (pick < 95) begin
      // malformed operands on set date / set time
      a.opcode = $urandom_range(0, 1) ? OP_SET_DATE : OP_SET_TIME;
    end else begin
      a.opcode = OP_UNUSED;
    end
    return a;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: default limits, reset date, month ends, rejects
    send_access(make_access(OP_READ, DAY_SECS * 3 + 5, 0, 0, 0, 0, 0, 0));
    send_access(make_access(OP_READ, DAY_SECS - 1, 0, 0, 0, 0, 0, 0));
    send_access(make_access(OP_SET_DATE, 10, 0, 0, 0, 28, 2, 2020));
    send_access(make_access(OP_READ, DAY_SECS * 2 + 3661, 0, 0, 0, 0, 0, 0));
    send_access(make_access(OP_SET_DATE, DAY_SECS, 0, 0, 0, 28, 2, 2019));
    send_access(make_access(OP_READ, DAY_SECS, 0, 0, 0, 0, 0, 0));
    send_access(make_access(OP_SET_DATE, DAY_SECS - 1, 0, 0, 0, 30, 2, 2000));
    send_access(make_access(OP_READ, DAY_SECS, 0, 0, 0, 0, 0, 0));
    send_access(make_access(OP_SET_DATE, '1, 0, 0, 0, 31, 12, 2019));
    send_access(make_access(OP_READ, DAY_SECS + 1, 0, 0, 0, 0, 0, 0));
    send_access(make_access(OP_SET_DATE, 0, 0, 0, 0, 0, 5, 1993));
    send_access(make_access(OP_READ, DAY_SECS * 2, 0, 0, 0, 0, 0, 0));
    send_access(make_access(OP_SET_DATE, 0, 0, 0, 0, 7, 0, 2000));
    send_access(make_access(OP_READ, DAY_SECS * 5, 0, 0, 0, 0, 0, 0));
    send_access(make_access(OP_SET_DATE, 0, 0, 0, 0, 32, 1, 2000));
    send_access(make_access(OP_SET_DATE, 0, 0, 0, 0, 1, 13, 2000));
    send_access(make_access(OP_SET_DATE, 0, 0, 0, 0, 1, 1, 1992));
    send_access(make_access(OP_SET_DATE, 0, 0, 0, 0, 1, 1, 2021));
    send_access(make_access(OP_SET_TIME, 0, 23, 59, 59, 0, 0, 0));
    send_access(make_access(OP_SET_TIME, 0, 24, 0, 0, 0, 0, 0));
    send_access(make_access(OP_SET_TIME, 0, 0, 60, 0, 0, 0, 0));
    send_access(make_access(OP_SET_TIME, 0, 0, 0, 60, 0, 0, 0));
    send_access(make_access(OP_UNUSED, '1, '1, '1, '1, '1, '1, '1));
    send_access(make_access(OP_READ, '1, 0, 0, 0, 0, 0, 0));

    // Phases over several year windows, extremes included
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_limits(16'd1993, 16'd2020);
        1: begin
          set_limits(16'd0, 16'hFFFF);
          send_access(make_access(OP_SET_DATE, 0, 0, 0, 0, 31, 12, 16'hFFFF));
          send_access(make_access(OP_READ, DAY_SECS, 0, 0, 0, 0, 0, 0));
          send_access(make_access(OP_SET_DATE, 0, 0, 0, 0, 28, 2, 1900));
          send_access(make_access(OP_READ, DAY_SECS, 0, 0, 0, 0, 0, 0));
        end
        2: set_limits(16'd2000, 16'd2000);
        3: set_limits(16'hFFFF, 16'd0);
        default: set_limits(16'($urandom), 16'($urandom));
      endcase
      repeat (275) send_access(random_access());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("rtc_time_and_calendar_core regression: pass");
    end else begin
      $display("rtc_time_and_calendar_core regression: fail");
    end
    $finish;
  end

endmodule
